// ===== rtl/fpa_pkg.sv =====
// Shared constants, command codes and control structs of the fixed partition allocator.
`default_nettype none

package fpa_pkg;

    // Default sizes of the block table.
    localparam int DEF_MAX_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 16;

    // Fixed widths of the port fields.
    localparam int CMD_W      = 2;
    localparam int BLK_IDX_W  = 4;
    localparam int SIZE_IN_W  = 16;
    localparam int POLICY_W   = 2;
    localparam int ACTIVE_W   = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;

    // Fit policy codes.
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BLOCKS = 2'd1;

    // Reset value of the active block count.
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // write the block size table
        logic clear;       // free every block
        logic scan_init;   // latch the request and restart the scan
        logic issue;       // read the next table entry
        logic finish;      // commit the pick and form the result
        logic zero_result; // result of a command that allocates nothing
    } fpa_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // every active entry has been read
    } fpa_stat_t;

endpackage

`default_nettype wire

// ===== rtl/fpa_ctrl.sv =====
// Controller state machine of the fixed partition allocator.
`default_nettype none

module fpa_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic [fpa_pkg::CMD_W-1:0] command,
    input  wire fpa_pkg::fpa_stat_t      stat,
    output fpa_pkg::fpa_cmd_t            cmd,
    output logic                         busy,
    output logic                         done
);
    import fpa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       done_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_ALLOC)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                    else
                    begin
                        cmd.load        = (command == CMD_LOAD);
                        cmd.clear       = (command == CMD_CLEAR);
                        cmd.zero_result = 1'b1;
                        done_next       = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // The last read is evaluated in the cycle that sees scan_done.
                if (stat.scan_done)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.issue = 1'b1;
                end
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ===== rtl/fpa_dp.sv =====
// Datapath of the fixed partition allocator: size table, used marks, scan and pick.
`default_nettype none

module fpa_dp #(
    parameter int MAX_BLOCKS = fpa_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fpa_pkg::DEF_SIZE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fpa_pkg::fpa_cmd_t               cmd,
    output fpa_pkg::fpa_stat_t                   stat,
    input  wire logic [fpa_pkg::BLK_IDX_W-1:0]   block_index,
    input  wire logic [fpa_pkg::SIZE_IN_W-1:0]   size_value,
    input  wire logic                            cfg_we,
    input  wire logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                                 granted,
    output logic [fpa_pkg::BLK_IDX_W-1:0]        chosen_block,
    output logic [fpa_pkg::SIZE_IN_W-1:0]        leftover
);
    import fpa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // Configuration registers.
    logic [POLICY_W-1:0] policy_reg;
    logic [ACTIVE_W-1:0] active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIRST;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:    policy_reg <= cfg_data[POLICY_W-1:0];
                CFG_ACTIVE_BLOCKS: active_reg <= cfg_data[ACTIVE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Entries past the table are not searched.
    logic [CNT_W-1:0] scan_len;
    assign scan_len = (32'(active_reg) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(active_reg);

    // Port fields brought to the internal widths.
    logic [IDX_W+BLK_IDX_W-1:0]     wr_idx_ext;
    logic [IDX_W-1:0]               wr_addr;
    logic                           wr_in_range;
    logic [SIZE_BITS+SIZE_IN_W-1:0] size_ext;
    logic [SIZE_BITS-1:0]           size_in;

    assign wr_idx_ext  = {{IDX_W{1'b0}}, block_index};
    assign wr_addr     = wr_idx_ext[IDX_W-1:0];
    assign wr_in_range = (32'(block_index) < MAX_BLOCKS);
    assign size_ext    = {{SIZE_BITS{1'b0}}, size_value};
    assign size_in     = size_ext[SIZE_BITS-1:0];

    // Scan counter.
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] rd_addr;

    assign rd_addr        = cnt_reg[IDX_W-1:0];
    assign stat.scan_done = (cnt_reg == scan_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.scan_init)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.issue)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Block size table with a registered read port.
    logic [SIZE_BITS-1:0] size_mem [MAX_BLOCKS];
    logic [SIZE_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_in_range)
        begin
            size_mem[wr_addr] <= size_in;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= size_mem[rd_addr];
        end
    end

    // The entry index travels alongside the read data.
    logic             eval_vld_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_vld_reg <= 1'b0;
            eval_idx_reg <= '0;
        end
        else
        begin
            eval_vld_reg <= cmd.issue;
            eval_idx_reg <= rd_addr;
        end
    end

    // Request and current pick.
    logic [SIZE_BITS-1:0] req_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_idx_reg;
    logic [SIZE_BITS-1:0] pick_size_reg;
    logic [MAX_BLOCKS-1:0] used_reg;
    logic                 fits;
    logic                 take;

    assign fits = eval_vld_reg && !used_reg[eval_idx_reg] && (rd_data_reg >= req_reg);

    always_comb
    begin
        case (policy_reg)
            POL_FIRST: take = fits && !found_reg;
            POL_BEST:  take = fits && (!found_reg || (rd_data_reg < pick_size_reg));
            POL_WORST: take = fits && (rd_data_reg > pick_size_reg);
            default:   take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.scan_init)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            req_reg       <= size_in;
            pick_idx_reg  <= '0;
            pick_size_reg <= '0;
        end
        else if (take)
        begin
            pick_idx_reg  <= eval_idx_reg;
            pick_size_reg <= rd_data_reg;
        end
    end

    // Used marks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.clear)
        begin
            used_reg <= '0;
        end
        else if (cmd.finish && found_reg)
        begin
            used_reg[pick_idx_reg] <= 1'b1;
        end
    end

    // Result registers.
    logic [SIZE_BITS-1:0]           diff;
    logic [SIZE_BITS+SIZE_IN_W-1:0] diff_ext;
    logic [IDX_W+BLK_IDX_W-1:0]     pick_ext;
    logic                           granted_reg;
    logic [BLK_IDX_W-1:0]           chosen_reg;
    logic [SIZE_IN_W-1:0]           leftover_reg;

    assign diff     = pick_size_reg - req_reg;
    assign diff_ext = {{SIZE_IN_W{1'b0}}, diff};
    assign pick_ext = {{BLK_IDX_W{1'b0}}, pick_idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            granted_reg  <= 1'b0;
            chosen_reg   <= '0;
            leftover_reg <= '0;
        end
        else if (cmd.zero_result)
        begin
            granted_reg  <= 1'b0;
            chosen_reg   <= '0;
            leftover_reg <= '0;
        end
        else if (cmd.finish)
        begin
            granted_reg  <= found_reg;
            chosen_reg   <= found_reg ? pick_ext[BLK_IDX_W-1:0] : '0;
            leftover_reg <= found_reg ? diff_ext[SIZE_IN_W-1:0] : '0;
        end
    end

    assign granted      = granted_reg;
    assign chosen_block = chosen_reg;
    assign leftover     = leftover_reg;

endmodule

`default_nettype wire

// ===== rtl/fixed_partition_allocator_unit.sv =====
// Top level of the fixed partition allocator: controller, datapath and configuration port.
`default_nettype none

// Load, clear and unknown commands give their result strobe in the cycle after the transfer.
// An allocate scans N = min(active_blocks, MAX_BLOCKS) entries through the one read port
// of the size table, one entry a cycle; busy stays high through the scan and finish states.
// The result is registered from the finish state; the next command may start as it shows.
// The result strobe lasts one cycle and the receiver cannot stall it.
// Reset clears the used marks and the control state and sets fit_policy to first fit and
// active_blocks to 16; the size table holds no defined value until it is loaded.
module fixed_partition_allocator_unit #(
    parameter int MAX_BLOCKS = fpa_pkg::DEF_MAX_BLOCKS,
    parameter int SIZE_BITS  = fpa_pkg::DEF_SIZE_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Command channel.
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [fpa_pkg::CMD_W-1:0]       command,
    input  wire logic [fpa_pkg::BLK_IDX_W-1:0]   block_index,
    input  wire logic [fpa_pkg::SIZE_IN_W-1:0]   size_value,
    // Result channel.
    output logic                                 done,
    output logic                                 granted,
    output logic [fpa_pkg::BLK_IDX_W-1:0]        chosen_block,
    output logic [fpa_pkg::SIZE_IN_W-1:0]        leftover,
    // Configuration write channel.
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [fpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fpa_pkg::*;

    fpa_cmd_t  cmd;
    fpa_stat_t stat;

    // Configuration registers take a transfer in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences each command; it sees only start, command and scan status.
    fpa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy),
        .done    (done)
    );

    // The datapath holds the table, the used marks, the scan pointer and the running pick.
    fpa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .block_index  (block_index),
        .size_value   (size_value),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .granted      (granted),
        .chosen_block (chosen_block),
        .leftover     (leftover)
    );

`ifndef SYNTHESIS
    // A refused request reports neither a block nor a fragment.
    a_reject_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !granted) |-> (chosen_block == '0) && (leftover == '0))
        else $error("refused request carries a nonzero index or leftover");

    // Commands other than allocate answer in the next cycle.
    a_short_cmd_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_ALLOC)) |=> done)
        else $error("load, clear or unknown command gave no result");

    // An allocate occupies the block and gives no result in the next cycle.
    a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == CMD_ALLOC)) |=> (busy && !done))
        else $error("allocate did not start a scan");

    // A result is only shown once the block has gone idle again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while the scan is still running");
`endif

endmodule

`default_nettype wire

// ===== dv/fixed_partition_allocator_unit_test.sv =====
// Self-checking testbench of the fixed partition allocator with its own prediction of every grant.
module fixed_partition_allocator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fpa_pkg::*;

    // The design is built with its default table, so the predictor uses the same sizes.
    localparam int MAX_BLOCKS = DEF_MAX_BLOCKS;

    // Codes that the package leaves unnamed but that the port fields can still carry.
    localparam logic [CMD_W-1:0]     CMD_UNKNOWN = 2'd3;
    localparam logic [POLICY_W-1:0]  POL_UNKNOWN = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    // Run shape. The quiet limit is far beyond the slowest correct gap between two transfers,
    // a full-table allocate and sender pauses included.
    localparam int QUIET_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 24;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 40;

    // One allocation result as it leaves the block.
    typedef struct packed {
        logic                 granted;
        logic [BLK_IDX_W-1:0] chosen_block;
        logic [SIZE_IN_W-1:0] leftover;
    } grant_t;

    // Every input is known from time zero; reset is held low from the start.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  start        = 1'b0;
    logic [CMD_W-1:0]      command      = CMD_LOAD;
    logic [BLK_IDX_W-1:0]  block_index  = '0;
    logic [SIZE_IN_W-1:0]  size_value   = '0;
    logic                  cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index    = CFG_FIT_POLICY;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    logic                  busy;
    logic                  done;
    logic                  granted;
    logic [BLK_IDX_W-1:0]  chosen_block;
    logic [SIZE_IN_W-1:0]  leftover;
    logic                  cfg_ready;

    // Predictor state: the partition table, the used marks and the two registers.
    logic [SIZE_IN_W-1:0]  part_size [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] part_used  = '0;
    logic [POLICY_W-1:0]   cur_policy = POL_FIRST;
    logic [ACTIVE_W-1:0]   cur_active = ACTIVE_RESET;

    // Grants predicted for accepted commands, oldest first.
    grant_t pending_grants [$];

    int unsigned fail_count = 0;
    int unsigned quiet_cycles = 0;
    // Percent chance that the sender holds start low before a command.
    int unsigned idle_pct = 0;

    fixed_partition_allocator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .block_index  (block_index),
        .size_value   (size_value),
        .done         (done),
        .granted      (granted),
        .chosen_block (chosen_block),
        .leftover     (leftover),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Applies one command to the predicted state and returns the result it must produce.
    // Loads, clears and unknown commands always answer with an all-zero result. An allocate
    // under a known policy scans the active entries; worst fit only takes a block strictly larger
    // than the best so far, starting from zero, which is why a zero-size block is never picked there.
    function automatic grant_t predict_command(input logic [CMD_W-1:0]     cmd,
                                               input logic [BLK_IDX_W-1:0] idx,
                                               input logic [SIZE_IN_W-1:0] val);
        grant_t               res;
        int unsigned          scan_len;
        logic                 found;
        logic                 take;
        logic [BLK_IDX_W-1:0] ent;
        logic [BLK_IDX_W-1:0] pick;
        logic [SIZE_IN_W-1:0] pick_size;
        res       = '0;
        found     = 1'b0;
        pick      = '0;
        pick_size = '0;
        case (cmd)
            CMD_LOAD:  part_size[idx] = val;
            CMD_CLEAR: part_used = '0;
            CMD_ALLOC: begin
                if (cur_policy != POL_UNKNOWN) begin
                    scan_len = (cur_active > MAX_BLOCKS) ? MAX_BLOCKS : cur_active;
                    for (int j = 0; j < scan_len; j++) begin
                        ent = BLK_IDX_W'(j);
                        if (!part_used[ent] && part_size[ent] >= val) begin
                            if (cur_policy == POL_FIRST)
                                take = !found;
                            else if (cur_policy == POL_BEST)
                                take = !found || part_size[ent] < pick_size;
                            else
                                take = part_size[ent] > pick_size;
                            if (take) begin
                                found     = 1'b1;
                                pick      = ent;
                                pick_size = part_size[ent];
                            end
                        end
                    end
                    if (found) begin
                        part_used[pick]  = 1'b1;
                        res.granted      = 1'b1;
                        res.chosen_block = pick;
                        res.leftover     = pick_size - val;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Sends one command. Before it the sender may idle for a random stretch; the command is
    // a transfer at the first rising edge with start high and busy low, and only then is its
    // grant predicted. Start is left high so that a following command can go back to back.
    task automatic send_command(input logic [CMD_W-1:0]     cmd,
                                input logic [BLK_IDX_W-1:0] idx,
                                input logic [SIZE_IN_W-1:0] val);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
            // Now and then a longer pause that spans a whole scan.
            if ($urandom_range(99) < 4)
                repeat ($urandom_range(30)) @(posedge clk);
        end
        start       <= 1'b1;
        command     <= cmd;
        block_index <= idx;
        size_value  <= val;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_grants.push_back(predict_command(cmd, idx, val));
    endtask

    // Lowers start and waits until every predicted grant has come back. At least one edge
    // passes, so start never gets two assignments in one time step.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (pending_grants.size() != 0);
    endtask

    // Writes one configuration register while the block is idle. Every command answers, so
    // the block is idle as soon as the last grant has come back.
    task automatic write_register(input logic [CFG_IDX_W-1:0]  idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_FIT_POLICY)
            cur_policy = data[POLICY_W-1:0];
        else if (idx == CFG_ACTIVE_BLOCKS)
            cur_active = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Fills every table entry once, so that no later search reads an entry never loaded.
    // The sizes hold both extremes, ties and a zero-size block at index 0.
    task automatic test_table_load();
        logic [SIZE_IN_W-1:0] sz;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            case (i)
                0:       sz = 16'd0;
                1, 7:    sz = 16'd500;
                2, 6:    sz = 16'd200;
                3:       sz = 16'd100;
                4, 15:   sz = 16'hFFFF;
                5:       sz = 16'd300;
                8:       sz = 16'd1;
                9:       sz = 16'd1000;
                10:      sz = 16'd4096;
                11:      sz = 16'd250;
                12:      sz = 16'd7;
                13:      sz = 16'h8000;
                default: sz = 16'd150;
            endcase
            send_command(CMD_LOAD, BLK_IDX_W'(i), sz);
        end
    endtask

    // First fit with the reset settings: an ordinary request, a zero request, a full-size request
    // with no fragment left, a tie on the largest size, and a request that fits nowhere.
    task automatic test_first_fit_defaults();
        send_command(CMD_ALLOC, 4'd0, 16'd150);
        send_command(CMD_ALLOC, 4'd0, 16'd0);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF);
    endtask

    // An unknown command changes nothing; a clear frees every block for a new run.
    task automatic test_clear_and_unknown();
        send_command(CMD_UNKNOWN, 4'd15, 16'hFFFF);
        send_command(CMD_CLEAR, 4'd15, 16'hFFFF);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF);
    endtask

    // Best fit and worst fit with their tie rules, and a policy code with no meaning.
    // The upper data bits of the policy write are set to check that they are dropped.
    task automatic test_fit_policies();
        write_register(CFG_FIT_POLICY, {3'b000, POL_BEST});
        send_command(CMD_CLEAR, 4'd0, 16'd0);
        send_command(CMD_ALLOC, 4'd0, 16'd150);
        send_command(CMD_ALLOC, 4'd0, 16'd150);
        send_command(CMD_ALLOC, 4'd0, 16'd190);
        write_register(CFG_FIT_POLICY, {3'b111, POL_WORST});
        send_command(CMD_CLEAR, 4'd0, 16'd0);
        send_command(CMD_ALLOC, 4'd0, 16'd150);
        send_command(CMD_ALLOC, 4'd0, 16'd150);
        write_register(CFG_FIT_POLICY, {3'b000, POL_UNKNOWN});
        send_command(CMD_ALLOC, 4'd0, 16'd0);
    endtask

    // Active block count at its extremes: none, one, and above the table size. With one
    // active block of size zero, worst fit refuses it. Writes to the spare indexes must not
    // disturb either register.
    task automatic test_active_limits();
        write_register(CFG_FIT_POLICY, {3'b000, POL_WORST});
        write_register(CFG_ACTIVE_BLOCKS, 5'd1);
        send_command(CMD_CLEAR, 4'd0, 16'd0);
        send_command(CMD_ALLOC, 4'd0, 16'd0);
        write_register(CFG_FIT_POLICY, {3'b000, POL_FIRST});
        write_register(CFG_ACTIVE_BLOCKS, 5'd0);
        send_command(CMD_ALLOC, 4'd0, 16'd0);
        write_register(CFG_ACTIVE_BLOCKS, 5'd31);
        write_register(CFG_SPARE_A, 5'h1F);
        write_register(CFG_SPARE_B, 5'h0A);
        send_command(CMD_ALLOC, 4'd0, 16'hFFFF);
        send_command(CMD_ALLOC, 4'd0, 16'd1);
        write_register(CFG_ACTIVE_BLOCKS, ACTIVE_RESET);
    endtask

    // Random traffic in phases. Each phase has its own policy, active count and sender
    // idling. Most commands are allocates, with request sizes drawn often near sizes in the
    // table so that grants, exact fits and near misses are common; loads change the table
    // and clears start new runs often enough that the table does not stay full.
    task automatic test_random_traffic();
        logic [POLICY_W-1:0]  pol;
        logic [ACTIVE_W-1:0]  act;
        logic [SIZE_IN_W-1:0] val;
        logic [BLK_IDX_W-1:0] idx;
        int unsigned          roll;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       begin pol = POL_FIRST;   act = 5'd16; end
                1:       begin pol = POL_BEST;    act = 5'd16; end
                2:       begin pol = POL_WORST;   act = 5'd16; end
                3:       begin pol = POL_FIRST;   act = 5'd31; end
                4:       begin pol = POL_BEST;    act = ACTIVE_W'($urandom_range(2, 15)); end
                5:       begin pol = POL_WORST;   act = 5'd17; end
                6:       begin pol = POL_UNKNOWN; act = 5'd16; end
                7:       begin pol = POL_BEST;    act = 5'd1; end
                8:       begin pol = POL_FIRST;   act = 5'd0; end
                default: begin pol = POL_WORST;   act = ACTIVE_W'($urandom_range(0, 31)); end
            endcase
            write_register(CFG_FIT_POLICY, {3'($urandom_range(7)), pol});
            write_register(CFG_ACTIVE_BLOCKS, act);
            case (phase % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 63;
                default: idle_pct = 30;
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // Once in mid-phase the sender holds off until the block has answered all.
                if (phase == 4 && k == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                roll = $urandom_range(99);
                idx  = BLK_IDX_W'($urandom_range(MAX_BLOCKS - 1));
                if (roll < 18) begin
                    roll = $urandom_range(99);
                    if (roll < 10)
                        val = '0;
                    else if (roll < 18)
                        val = '1;
                    else if (roll < 60)
                        val = SIZE_IN_W'($urandom_range(1, 2048));
                    else
                        val = SIZE_IN_W'($urandom_range(0, 65535));
                    send_command(CMD_LOAD, idx, val);
                end else if (roll < 24) begin
                    send_command(CMD_CLEAR, idx, SIZE_IN_W'($urandom_range(0, 65535)));
                end else if (roll < 27) begin
                    send_command(CMD_UNKNOWN, idx, SIZE_IN_W'($urandom_range(0, 65535)));
                end else begin
                    roll = $urandom_range(99);
                    if (roll < 45) begin
                        val = part_size[BLK_IDX_W'($urandom_range(MAX_BLOCKS - 1))];
                        if ($urandom_range(1) && val > 3)
                            val = val - SIZE_IN_W'($urandom_range(3));
                    end else if (roll < 55) begin
                        val = '0;
                    end else if (roll < 62) begin
                        val = '1;
                    end else if (roll < 80) begin
                        val = SIZE_IN_W'($urandom_range(0, 1023));
                    end else begin
                        val = SIZE_IN_W'($urandom_range(0, 65535));
                    end
                    send_command(CMD_ALLOC, idx, val);
                end
            end
        end
        idle_pct = 0;
    endtask

    // Result checker. A result is one strobed cycle and is taken at the edge that ends it;
    // it is compared field by field with the oldest prediction.
    always @(posedge clk) begin : check_result
        grant_t want;
        if (rst_n && done) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: result with no command pending: granted %0b block %0d leftover %0d",
                         $time, granted, chosen_block, leftover);
                fail_count++;
            end else begin
                want = pending_grants.pop_front();
                if (granted !== want.granted) begin
                    $display("%0t: granted mismatch, expected %0b, actual %0b",
                             $time, want.granted, granted);
                    fail_count++;
                end
                if (chosen_block !== want.chosen_block) begin
                    $display("%0t: chosen_block mismatch, expected %0d, actual %0d",
                             $time, want.chosen_block, chosen_block);
                    fail_count++;
                end
                if (leftover !== want.leftover) begin
                    $display("%0t: leftover mismatch, expected %0d, actual %0d",
                             $time, want.leftover, leftover);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog. Any command transfer, result or register transfer counts as progress; a long
    // run of cycles without any of them means the block has hung.
    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Test sequence: reset once, the directed cases, then the random phases, then a drain
    // and a tail longer than the slowest scan before the verdict.
    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_first_fit_defaults();
        test_clear_and_unknown();
        test_fit_policies();
        test_active_limits();
        test_random_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
